// ----- rtl/sbcp_pkg.sv -----
// Shared types, constants and register codes for the signed blob container parser.
`default_nettype none

package sbcp_pkg;

   localparam int COUNT_BITS_DEFAULT = 17;
   localparam int MIN_SIZE = 7;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [15:0] EXPECTED_VERSION_RESET = 16'd1;
   localparam logic [7:0] ALGORITHM_CODE_A_RESET = 8'd1;
   localparam logic [7:0] ALGORITHM_CODE_B_RESET = 8'd0;

   localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
   localparam logic [1:0] REG_ALGORITHM_CODE_A = 2'd1;
   localparam logic [1:0] REG_ALGORITHM_CODE_B = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_VERSION = 3'd2;
   localparam logic [2:0] ST_FORMAT = 3'd3;
   localparam logic [2:0] ST_OVERRUN = 3'd4;

   localparam logic [2:0] ROLE_VERSION = 3'd0;
   localparam logic [2:0] ROLE_CHAIN_LENGTH = 3'd1;
   localparam logic [2:0] ROLE_CERT_PREFIX = 3'd2;
   localparam logic [2:0] ROLE_CERT_CONTENT = 3'd3;
   localparam logic [2:0] ROLE_ALGORITHM = 3'd4;
   localparam logic [2:0] ROLE_SIG_LENGTH = 3'd5;
   localparam logic [2:0] ROLE_SIG_BYTE = 3'd6;
   localparam logic [2:0] ROLE_TRAILING = 3'd7;

   typedef enum logic [3:0] {
      PH_VER_HI,
      PH_VER_LO,
      PH_CHN_HI,
      PH_CHN_LO,
      PH_PFX_HI,
      PH_PFX_LO,
      PH_CONTENT,
      PH_ALG,
      PH_SIG_HI,
      PH_SIG_LO,
      PH_SIG,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  byte_role;
      logic        done_res;
      logic [2:0]  status;
      logic [15:0] cert_chain_bytes;
      logic [15:0] sig_length;
      logic [7:0]  algorithm;
   } rsp_type;

   typedef struct packed {
      logic [15:0] expected_version;
      logic [7:0]  algorithm_code_a;
      logic [7:0]  algorithm_code_b;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/sbcp_csr.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none

module sbcp_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [sbcp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [sbcp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [sbcp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                      pready,
   output sbcp_pkg::cfg_type                         cfg
);

   sbcp_pkg::cfg_type cfg_ff;
   logic              write_en;
   logic [1:0]        reg_index;

   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[3:2];
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= sbcp_pkg::EXPECTED_VERSION_RESET;
         cfg_ff.algorithm_code_a <= sbcp_pkg::ALGORITHM_CODE_A_RESET;
         cfg_ff.algorithm_code_b <= sbcp_pkg::ALGORITHM_CODE_B_RESET;
      end else if (write_en) begin
         case (reg_index)
            sbcp_pkg::REG_EXPECTED_VERSION: cfg_ff.expected_version <= pwdata[15:0];
            sbcp_pkg::REG_ALGORITHM_CODE_A: cfg_ff.algorithm_code_a <= pwdata[7:0];
            sbcp_pkg::REG_ALGORITHM_CODE_B: cfg_ff.algorithm_code_b <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         sbcp_pkg::REG_EXPECTED_VERSION: prdata = {16'd0, cfg_ff.expected_version};
         sbcp_pkg::REG_ALGORITHM_CODE_A: prdata = {24'd0, cfg_ff.algorithm_code_a};
         sbcp_pkg::REG_ALGORITHM_CODE_B: prdata = {24'd0, cfg_ff.algorithm_code_b};
         default:                        prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/sbcp_parse.sv -----
// Parse state and the single-pass step logic that tags and checks one byte.
`default_nettype none

module sbcp_parse #(
   parameter int COUNT_BITS = sbcp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire sbcp_pkg::req_type item,
   input  wire sbcp_pkg::cfg_type cfg,
   output sbcp_pkg::rsp_type      result
);

   sbcp_pkg::phase_type   phase_ff, phase_in;
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [7:0]            field_high_ff, field_high_in;
   logic [15:0]           chain_left_ff, chain_left_in;
   logic [15:0]           cert_left_ff, cert_left_in;
   logic [15:0]           sig_left_ff, sig_left_in;
   logic [2:0]            header_fault_ff, header_fault_in;
   logic [2:0]            chain_fault_ff, chain_fault_in;
   logic [15:0]           cert_total_ff, cert_total_in;
   logic [15:0]           sig_length_ff, sig_length_in;
   logic [7:0]            algorithm_ff, algorithm_in;

   logic [15:0]           field_v;
   logic [15:0]           chain_dec;
   logic [2:0]            prefix_fault;
   logic [2:0]            role;

   assign field_v   = {field_high_ff, item.data_byte};
   assign chain_dec = chain_left_ff - 16'd1;

   always_comb begin
      if (chain_fault_ff != sbcp_pkg::ST_OK) begin
         prefix_fault = chain_fault_ff;
      end else if (field_v == 16'd0) begin
         prefix_fault = sbcp_pkg::ST_FORMAT;
      end else if (field_v > chain_dec) begin
         prefix_fault = sbcp_pkg::ST_OVERRUN;
      end else begin
         prefix_fault = sbcp_pkg::ST_OK;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      field_high_in   = field_high_ff;
      chain_left_in   = chain_left_ff;
      cert_left_in    = cert_left_ff;
      sig_left_in     = sig_left_ff;
      header_fault_in = header_fault_ff;
      chain_fault_in  = chain_fault_ff;
      cert_total_in   = cert_total_ff;
      sig_length_in   = sig_length_ff;
      algorithm_in    = algorithm_ff;
      byte_count_in   = (byte_count_ff != '1) ? byte_count_ff + COUNT_BITS'(1) : byte_count_ff;

      case (phase_ff)
         sbcp_pkg::PH_VER_HI: begin
            field_high_in = item.data_byte;
            phase_in      = sbcp_pkg::PH_VER_LO;
         end
         sbcp_pkg::PH_VER_LO: begin
            if (field_v != cfg.expected_version && header_fault_ff == sbcp_pkg::ST_OK) begin
               header_fault_in = sbcp_pkg::ST_VERSION;
            end
            phase_in = sbcp_pkg::PH_CHN_HI;
         end
         sbcp_pkg::PH_CHN_HI: begin
            field_high_in = item.data_byte;
            phase_in      = sbcp_pkg::PH_CHN_LO;
         end
         sbcp_pkg::PH_CHN_LO: begin
            chain_left_in = field_v;
            if (field_v == 16'd0) begin
               if (chain_fault_ff == sbcp_pkg::ST_OK) begin
                  chain_fault_in = sbcp_pkg::ST_FORMAT;
               end
               phase_in = sbcp_pkg::PH_ALG;
            end else begin
               phase_in = sbcp_pkg::PH_PFX_HI;
            end
         end
         sbcp_pkg::PH_PFX_HI: begin
            field_high_in = item.data_byte;
            chain_left_in = chain_dec;
            if (chain_dec == 16'd0) begin
               if (chain_fault_ff == sbcp_pkg::ST_OK) begin
                  chain_fault_in = sbcp_pkg::ST_OVERRUN;
               end
               phase_in = sbcp_pkg::PH_ALG;
            end else begin
               phase_in = sbcp_pkg::PH_PFX_LO;
            end
         end
         sbcp_pkg::PH_PFX_LO: begin
            chain_left_in  = chain_dec;
            chain_fault_in = prefix_fault;
            if (prefix_fault != sbcp_pkg::ST_OK) begin
               cert_left_in = chain_dec;
               phase_in     = (chain_dec == 16'd0) ? sbcp_pkg::PH_ALG : sbcp_pkg::PH_CONTENT;
            end else begin
               cert_left_in = field_v;
               phase_in     = sbcp_pkg::PH_CONTENT;
            end
         end
         sbcp_pkg::PH_CONTENT: begin
            if (chain_left_ff != 16'd0) begin
               chain_left_in = chain_dec;
            end
            if (cert_left_ff != 16'd0) begin
               cert_left_in = cert_left_ff - 16'd1;
            end
            if (chain_fault_ff == sbcp_pkg::ST_OK && cert_total_ff != 16'hFFFF) begin
               cert_total_in = cert_total_ff + 16'd1;
            end
            if (cert_left_in == 16'd0) begin
               phase_in = (chain_left_in == 16'd0) ? sbcp_pkg::PH_ALG : sbcp_pkg::PH_PFX_HI;
            end
         end
         sbcp_pkg::PH_ALG: begin
            algorithm_in = item.data_byte;
            if (item.data_byte != cfg.algorithm_code_a && item.data_byte != cfg.algorithm_code_b
                && header_fault_ff == sbcp_pkg::ST_OK) begin
               header_fault_in = sbcp_pkg::ST_FORMAT;
            end
            phase_in = sbcp_pkg::PH_SIG_HI;
         end
         sbcp_pkg::PH_SIG_HI: begin
            field_high_in = item.data_byte;
            phase_in      = sbcp_pkg::PH_SIG_LO;
         end
         sbcp_pkg::PH_SIG_LO: begin
            sig_length_in = field_v;
            sig_left_in   = field_v;
            if (field_v == 16'd0) begin
               if (chain_fault_ff == sbcp_pkg::ST_OK) begin
                  chain_fault_in = sbcp_pkg::ST_FORMAT;
               end
               phase_in = sbcp_pkg::PH_TRAIL;
            end else begin
               phase_in = sbcp_pkg::PH_SIG;
            end
         end
         sbcp_pkg::PH_SIG: begin
            if (sig_left_ff != 16'd0) begin
               sig_left_in = sig_left_ff - 16'd1;
            end
            if (sig_left_in == 16'd0) begin
               phase_in = sbcp_pkg::PH_TRAIL;
            end
         end
         default: begin
            phase_in = sbcp_pkg::PH_TRAIL;
         end
      endcase

      if (item.last_byte) begin
         if (byte_count_in < COUNT_BITS'(sbcp_pkg::MIN_SIZE)) begin
            header_fault_in = sbcp_pkg::ST_SHORT;
         end else if (phase_in != sbcp_pkg::PH_TRAIL
                      && header_fault_in == sbcp_pkg::ST_OK) begin
            header_fault_in = sbcp_pkg::ST_FORMAT;
         end
      end
   end

   always_comb begin
      case (phase_ff)
         sbcp_pkg::PH_VER_HI:  role = sbcp_pkg::ROLE_VERSION;
         sbcp_pkg::PH_VER_LO:  role = sbcp_pkg::ROLE_VERSION;
         sbcp_pkg::PH_CHN_HI:  role = sbcp_pkg::ROLE_CHAIN_LENGTH;
         sbcp_pkg::PH_CHN_LO:  role = sbcp_pkg::ROLE_CHAIN_LENGTH;
         sbcp_pkg::PH_PFX_HI:  role = sbcp_pkg::ROLE_CERT_PREFIX;
         sbcp_pkg::PH_PFX_LO:  role = sbcp_pkg::ROLE_CERT_PREFIX;
         sbcp_pkg::PH_CONTENT: role = sbcp_pkg::ROLE_CERT_CONTENT;
         sbcp_pkg::PH_ALG:     role = sbcp_pkg::ROLE_ALGORITHM;
         sbcp_pkg::PH_SIG_HI:  role = sbcp_pkg::ROLE_SIG_LENGTH;
         sbcp_pkg::PH_SIG_LO:  role = sbcp_pkg::ROLE_SIG_LENGTH;
         sbcp_pkg::PH_SIG:     role = sbcp_pkg::ROLE_SIG_BYTE;
         default:              role = sbcp_pkg::ROLE_TRAILING;
      endcase

      result.out_byte         = item.data_byte;
      result.byte_role        = role;
      result.done_res         = item.last_byte;
      result.status           = (header_fault_in != sbcp_pkg::ST_OK) ? header_fault_in
                                                                     : chain_fault_in;
      result.cert_chain_bytes = cert_total_in;
      result.sig_length       = sig_length_in;
      result.algorithm        = algorithm_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last_byte)) begin
         phase_ff        <= sbcp_pkg::PH_VER_HI;
         byte_count_ff   <= '0;
         field_high_ff   <= '0;
         chain_left_ff   <= '0;
         cert_left_ff    <= '0;
         sig_left_ff     <= '0;
         header_fault_ff <= sbcp_pkg::ST_OK;
         chain_fault_ff  <= sbcp_pkg::ST_OK;
         cert_total_ff   <= '0;
         sig_length_ff   <= '0;
         algorithm_ff    <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         field_high_ff   <= field_high_in;
         chain_left_ff   <= chain_left_in;
         cert_left_ff    <= cert_left_in;
         sig_left_ff     <= sig_left_in;
         header_fault_ff <= header_fault_in;
         chain_fault_ff  <= chain_fault_in;
         cert_total_ff   <= cert_total_in;
         sig_length_ff   <= sig_length_in;
         algorithm_ff    <= algorithm_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && item.last_byte |=> phase_ff == sbcp_pkg::PH_VER_HI && byte_count_ff == '0)
      else $error("parse state not restarted after the last byte");

   a_version_at_head: assert property (@(posedge clock) disable iff (reset)
      advance && result.byte_role == sbcp_pkg::ROLE_VERSION |-> byte_count_ff < COUNT_BITS'(2))
      else $error("version role outside the first two bytes");

   a_no_count_after_fault: assert property (@(posedge clock) disable iff (reset)
      advance && !item.last_byte && chain_fault_ff != sbcp_pkg::ST_OK
      |=> $stable(cert_total_ff))
      else $error("certificate bytes counted after a chain fault");

endmodule

`default_nettype wire

// ----- rtl/signed_blob_container_parser.sv -----
// Top level of the signed blob container parser: request and result registers around the step logic.
//
//   channel    direction  handshake                          payload
//   request    in         req_valid / req_stall              req_payload (sbcp_pkg::req_type)
//   result     out        rsp_valid / rsp_stall              rsp_payload (sbcp_pkg::rsp_type)
//   registers  in/out     psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// One request is accepted per clock cycle while req_stall is low; each request goes from the
// request register through the step logic into the result register, held there under rsp_stall.
// Reset is synchronous and returns the parse state and the registers to their reset values.
// A held result stalls the request register, and req_stall rises only when both registers are
// full and the result is stalled.
`default_nettype none

module signed_blob_container_parser #(
   parameter int COUNT_BITS = sbcp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire sbcp_pkg::req_type                    req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output sbcp_pkg::rsp_type                         rsp_payload,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [sbcp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [sbcp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [sbcp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                      pready
);

   sbcp_pkg::cfg_type cfg;
   sbcp_pkg::req_type in_item_ff;
   sbcp_pkg::rsp_type out_item_ff;
   sbcp_pkg::rsp_type step_result;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              advance;
   logic              req_take;

   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign rsp_valid    = out_valid_ff;
   assign rsp_payload  = out_item_ff;

   sbcp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sbcp_parse #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= sbcp_pkg::ST_OVERRUN)
      else $error("result status outside the defined codes");

   a_request_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("held request did not move to the result register");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled while a register was free");

endmodule

`default_nettype wire
